// ===== sv/qecs_pkg.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter package
// Shared constants, register indexes and controller/datapath structs.
// ---------------------------------------------------------------------------
package qecs_pkg;

    // Default sizing of the block
    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths of the stream items
    localparam int CH_W     = 2;
    localparam int POS_W    = 32;
    localparam int SPEED_W  = 16;
    localparam int MULT_W   = 16;
    localparam int SHIFT_W  = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // Configuration register reset values
    localparam logic [MULT_W-1:0]  SPEED_MULT_RST  = 16'd9375;
    localparam logic [SHIFT_W-1:0] SPEED_SHIFT_RST = 5'd7;

    // Register indexes on the configuration port
    localparam logic REG_SPEED_MULT  = 1'b0;
    localparam logic REG_SPEED_SHIFT = 1'b1;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result kinds
    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_SPEED    = 1'b1;

    // Saturation limits of the speed field
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 16'h8000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic samp_go;   // update a channel and load a position result
        logic mul_go;    // form delta times multiplier for the current channel
        logic emit_go;   // load a speed report for the current channel
        logic last_ch;   // current channel is the final one of a tick
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ch_ok;     // sampled channel exists
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== sv/qecs_regs.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter configuration registers
// APB-style register file holding the speed multiplier and shift.
// ---------------------------------------------------------------------------
module qecs_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [qecs_pkg::MULT_W-1:0]   o_speed_mult,
    output logic [qecs_pkg::SHIFT_W-1:0]  o_speed_shift
);
    import qecs_pkg::*;

    logic                w_wr_en;
    logic [MULT_W-1:0]   r_speed_mult;
    logic [SHIFT_W-1:0]  r_speed_shift;

    assign pready  = 1'b1;
    assign w_wr_en = psel & penable & pwrite & pready;

    // Register writes on the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_mult  <= SPEED_MULT_RST;
            r_speed_shift <= SPEED_SHIFT_RST;
        end else if (w_wr_en) begin
            case (paddr[2])
                REG_SPEED_MULT:  r_speed_mult  <= pwdata[MULT_W-1:0];
                REG_SPEED_SHIFT: r_speed_shift <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register
    always_comb begin
        case (paddr[2])
            REG_SPEED_MULT:  prdata = {{(32-MULT_W){1'b0}}, r_speed_mult};
            REG_SPEED_SHIFT: prdata = {{(32-SHIFT_W){1'b0}}, r_speed_shift};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_speed_mult  = r_speed_mult;
    assign o_speed_shift = r_speed_shift;

endmodule

// ===== sv/qecs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter controller
// Sequences sample updates and the per-channel steps of a speed tick.
// ---------------------------------------------------------------------------
module qecs_ctrl #(
    parameter  int CHANNELS = qecs_pkg::CHANNELS_DEF,
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tuser,
    output logic               o_s_tready,
    input  qecs_pkg::t_status  i_status,
    output qecs_pkg::t_cmd     o_cmd,
    output logic [IDX_W-1:0]   o_idx
);
    import qecs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SAMP = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_last;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_last     = (r_idx == IDX_LAST);

    // Next-state and command decode
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.last_ch = w_last;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_idx         = '0;
                    n_state       = (i_s_tuser == OP_TICK) ? ST_MUL : ST_SAMP;
                end
            end
            ST_SAMP: begin
                // A sample for a channel that does not exist gives no result.
                if (!i_status.ch_ok) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.samp_go = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_go = 1'b1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and channel counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

// ===== sv/qecs_dp.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter datapath
// Per-channel phase and count storage, speed scaling and output register.
// ---------------------------------------------------------------------------
module qecs_dp #(
    parameter  int CHANNELS   = qecs_pkg::CHANNELS_DEF,
    parameter  int COUNT_BITS = qecs_pkg::COUNT_BITS_DEF,
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qecs_pkg::t_cmd                     i_cmd,
    input  logic [IDX_W-1:0]                   i_idx,
    output qecs_pkg::t_status                  o_status,
    input  logic [qecs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic [qecs_pkg::MULT_W-1:0]        i_speed_mult,
    input  logic [qecs_pkg::SHIFT_W-1:0]       i_speed_shift,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [qecs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import qecs_pkg::*;

    localparam int PW = COUNT_BITS + MULT_W;

    // Input item register
    logic             r_op;
    logic [CH_W-1:0]  r_ch;
    logic [1:0]       r_phase;

    // Channel state
    logic [1:0]            r_last_phase [CHANNELS];
    logic [COUNT_BITS-1:0] r_count      [CHANNELS];
    logic [COUNT_BITS-1:0] r_cat        [CHANNELS];

    // Tick pipeline register
    logic            r_t_neg;
    logic [POS_W-1:0] r_t_pos;
    logic [PW-1:0]   r_prod;

    // Output register
    logic               r_m_valid;
    logic               r_kind;
    logic [CH_W-1:0]    r_out_ch;
    logic [POS_W-1:0]   r_pos;
    logic [SPEED_W-1:0] r_spd;
    logic               r_bad;
    logic               r_last;

    logic [IDX_W-1:0]      w_idx;
    logic [1:0]            w_prev;
    logic [1:0]            w_diff;
    logic                  w_bad;
    logic                  w_step;
    logic                  w_up;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] w_delta;
    logic                  w_neg;
    logic [COUNT_BITS-1:0] w_mag;
    logic [PW-1:0]         w_q;
    logic [SPEED_W-1:0]    w_speed;

    // Capture of an accepted input transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_s_tuser;
            r_ch    <= i_s_tdata[1:0];
            r_phase <= {i_s_tdata[2], i_s_tdata[3]};
        end
    end

    // Channel selection: the sampled channel, or the tick's channel counter
    assign w_idx = (r_op == OP_TICK) ? i_idx : IDX_W'(r_ch);

    assign o_status.ch_ok    = (32'(r_ch) < 32'(CHANNELS));
    assign o_status.out_free = !r_m_valid || i_m_tready;

    // Phase decode: one changed bit steps the count, two changed bits are an error.
    assign w_prev  = r_last_phase[w_idx];
    assign w_diff  = w_prev ^ r_phase;
    assign w_bad   = (w_diff == 2'b11);
    assign w_step  = (w_diff == 2'b01) || (w_diff == 2'b10);
    assign w_up    = (w_prev[0] == r_phase[1]);
    assign w_cur   = r_count[w_idx];
    assign n_count = !w_step ? w_cur :
                     w_up    ? w_cur + COUNT_BITS'(1) : w_cur - COUNT_BITS'(1);

    // Count change since the previous tick, as sign and magnitude
    assign w_delta = w_cur - r_cat[w_idx];
    assign w_neg   = w_delta[COUNT_BITS-1];
    assign w_mag   = w_neg ? (COUNT_BITS'(0) - w_delta) : w_delta;

    // Channel state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_phase[i] <= 2'b00;
                r_count[i]      <= '0;
                r_cat[i]        <= '0;
            end
        end else if (i_cmd.samp_go) begin
            r_last_phase[w_idx] <= r_phase;
            r_count[w_idx]      <= n_count;
        end else if (i_cmd.mul_go) begin
            r_cat[w_idx] <= w_cur;
        end
    end

    // Scaling multiply for one channel of a tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_t_neg <= w_neg;
            r_t_pos <= POS_W'(w_cur);
            r_prod  <= PW'(w_mag) * PW'(i_speed_mult);
        end
    end

    // Shift down and saturate to the signed speed range
    assign w_q = r_prod >> i_speed_shift;

    always_comb begin
        if (r_t_neg) begin
            if (w_q > PW'(SPEED_MIN)) begin
                w_speed = SPEED_MIN;
            end else begin
                w_speed = SPEED_W'(0) - w_q[SPEED_W-1:0];
            end
        end else if (w_q > PW'(SPEED_MAX)) begin
            w_speed = SPEED_MAX;
        end else begin
            w_speed = w_q[SPEED_W-1:0];
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.samp_go || i_cmd.emit_go) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.samp_go) begin
            r_kind   <= KIND_POSITION;
            r_out_ch <= r_ch;
            r_pos    <= POS_W'(n_count);
            r_spd    <= '0;
            r_bad    <= w_bad;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_go) begin
            r_kind   <= KIND_SPEED;
            r_out_ch <= CH_W'(i_idx);
            r_pos    <= r_t_pos;
            r_spd    <= w_speed;
            r_bad    <= 1'b0;
            r_last   <= i_cmd.last_ch;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, r_bad, r_spd, r_pos, r_out_ch};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

endmodule

// ===== sv/quad_encoder_counter_speed_top.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter with speed measurement, top level
// Multi-channel quadrature decoder with a periodic scaled speed report.
// ---------------------------------------------------------------------------
// Usage:
// The input stream carries one transaction per event: tuser = 0 is a pin
// sample of one channel, tuser = 1 is a speed tick. A sample returns one
// position update; a tick returns one speed report per channel, in channel
// order, with tlast on the final one. The output stream's tuser tells the
// two kinds apart.
// Sequencing: the block works on one event at a time. A sample loads its result
// into the output register from the SAMP state once that register is free,
// and the controller then returns to idle to take the next event. A tick
// steps through the channels in order, each with a MUL step to form delta
// times multiplier and an EMIT step to shift, saturate and load, using the
// single shared multiplier; after the last report the controller returns to
// idle to take the next event. A sample for a channel that does not exist is
// dropped without a result.
// Reset clears all phases, counts and tick snapshots at once and loads the
// register defaults; no clearing pass follows. When the receiver stalls,
// the result waits in the output register and the controller holds its
// next load into that register until the register frees.
// ---------------------------------------------------------------------------
module quad_encoder_counter_speed_top #(
    parameter int CHANNELS   = qecs_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = qecs_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] channel, [2] a_level, [3] b_level, [7:4] zero
    input  logic [qecs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [0] op
    input  logic                               i_s_tuser,
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] out_channel, [33:2] position, [49:34] speed, [50] bad_step,
    // [55:51] zero
    output logic [qecs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // [0] kind
    output logic                               o_m_tuser,
    output logic                               o_m_tlast,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import qecs_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cmd                w_cmd;
    t_status             w_status;
    logic [IDX_W-1:0]    w_idx;
    logic [MULT_W-1:0]   w_speed_mult;
    logic [SHIFT_W-1:0]  w_speed_shift;

    // Configuration registers
    qecs_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_speed_mult  (w_speed_mult),
        .o_speed_shift (w_speed_shift)
    );

    // Sequencing of samples and ticks
    qecs_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // Counts, scaling and output register
    qecs_dp #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .o_status      (w_status),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_speed_mult  (w_speed_mult),
        .i_speed_shift (w_speed_shift),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

// ===== sv/qecs_checker.sv =====
// ---------------------------------------------------------------------------
// Quadrature encoder counter port checker
// Concurrent assertions on the top level's streams, bound to the top level.
// ---------------------------------------------------------------------------
module qecs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [qecs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic                               o_m_tuser,
    input logic                               o_m_tlast
);
    import qecs_pkg::*;

    // A stalled result stays offered.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output transaction withdrawn while stalled");

    // One event at a time: after an accepted input the block is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while previous event still in progress");

    // A position update is always the only result of its event.
    a_position_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_POSITION) |-> o_m_tlast)
        else $error("position update without tlast");

    // A position update carries no speed.
    a_position_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_POSITION) |-> (o_m_tdata[49:34] == 16'd0))
        else $error("position update with nonzero speed");

endmodule

bind quad_encoder_counter_speed_top qecs_checker u_qecs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== dv/qecs_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quadrature encoder counter result checker
// Watches the input stream, the configuration port and the output stream.
// It keeps its own copy of the phases, counts and tick snapshots, works out
// the position updates and speed reports due for every accepted transaction,
// and compares each output transaction with the oldest one still awaited.
// ---------------------------------------------------------------------------
module qecs_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream as seen by the block
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // [1:0] channel, [2] a_level, [3] b_level, [7:4] zero
    input  logic [qecs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [0] op
    input  logic                               i_s_tuser,
    // Output stream as seen by the block
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] out_channel, [33:2] position, [49:34] speed, [50] bad_step,
    // [55:51] zero
    input  logic [qecs_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    // [0] kind
    input  logic                               i_m_tuser,
    input  logic                               i_m_tlast,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    input  logic                               pready,
    // Status towards the stimulus side
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import qecs_pkg::*;

    localparam int NCH = CHANNELS_DEF;

    typedef struct packed {
        logic               kind;
        logic [CH_W-1:0]    channel;
        logic [POS_W-1:0]   position;
        logic [SPEED_W-1:0] speed;
        logic               bad_step;
        logic               last;
    } t_report;

    t_report            awaited_reports[$];
    logic [MULT_W-1:0]  speed_mult;
    logic [SHIFT_W-1:0] speed_shift;
    logic [1:0]         phase_seen [NCH];
    logic [POS_W-1:0]   position [NCH];
    logic [POS_W-1:0]   position_at_tick [NCH];

    // Scales a count change by mult / 2^shift, truncating towards zero and
    // saturating to the signed 16-bit range.
    function automatic logic [SPEED_W-1:0] scaled_speed(input logic [POS_W-1:0] delta);
        logic              neg;
        logic [POS_W-1:0]  mag;
        logic [63:0]       quot;
        neg  = delta[POS_W-1];
        mag  = neg ? -delta : delta;
        quot = (64'(mag) * 64'(speed_mult)) >> speed_shift;
        if (neg) begin
            if (quot > 64'd32768)
                quot = 64'd32768;
            return ~quot[SPEED_W-1:0] + 1'b1;
        end
        if (quot > 64'd32767)
            quot = 64'd32767;
        return quot[SPEED_W-1:0];
    endfunction

    // A pin sample moves the count by one step on a single-bit phase change
    // and flags a change of both bits.
    task automatic predict_sample(input logic [CH_W-1:0] ch, input logic [1:0] curr);
        logic [1:0] prev;
        logic       bad;
        prev = phase_seen[ch];
        bad  = 1'b0;
        if ((prev ^ curr) == 2'b11) begin
            bad = 1'b1;
        end else if (prev != curr) begin
            if (prev[0] == curr[1])
                position[ch] = position[ch] + 1'b1;
            else
                position[ch] = position[ch] - 1'b1;
        end
        phase_seen[ch] = curr;
        awaited_reports.push_back('{KIND_POSITION, ch, position[ch], '0, bad, 1'b1});
    endtask

    // A tick reports every channel's scaled count change since the previous tick.
    task automatic predict_tick();
        for (int i = 0; i < NCH; i++) begin
            awaited_reports.push_back('{KIND_SPEED, CH_W'(i), position[i],
                scaled_speed(position[i] - position_at_tick[i]), 1'b0,
                (i == NCH - 1)});
            position_at_tick[i] = position[i];
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_mult  = SPEED_MULT_RST;
            speed_shift = SPEED_SHIFT_RST;
            for (int i = 0; i < NCH; i++) begin
                phase_seen[i]       = '0;
                position[i]         = '0;
                position_at_tick[i] = '0;
            end
            awaited_reports.delete();
        end else begin
            // Output transaction against the oldest awaited result
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h user %b last %b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count++;
                end else begin
                    t_report want;
                    want = awaited_reports.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_m_tuser));
                    check_field("out_channel", 32'(want.channel), 32'(i_m_tdata[1:0]));
                    check_field("position", want.position, i_m_tdata[33:2]);
                    check_field("speed", 32'(want.speed), 32'(i_m_tdata[49:34]));
                    check_field("bad_step", 32'(want.bad_step), 32'(i_m_tdata[50]));
                    check_field("last", 32'(want.last), 32'(i_m_tlast));
                end
            end

            // Register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_SPEED_MULT, 2'b00})
                    speed_mult = pwdata[MULT_W-1:0];
                else if (paddr == {REG_SPEED_SHIFT, 2'b00})
                    speed_shift = pwdata[SHIFT_W-1:0];
            end

            // Input transaction
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_TICK)
                    predict_tick();
                else if (i_s_tdata[1:0] < NCH)
                    predict_sample(i_s_tdata[1:0], {i_s_tdata[2], i_s_tdata[3]});
            end
        end
        o_pending = awaited_reports.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quadrature encoder counter testbench
// Drives directed and random pin samples and speed ticks through the block
// under several scaling settings, with random gaps on both streams and one
// long receiver hold-off. The result checker compares every output.
// ---------------------------------------------------------------------------
module testbench;
    import qecs_pkg::*;

    localparam int NCH         = CHANNELS_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 46;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata;
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     o_m_tuser;
    logic                     o_m_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int         fail_count;
    int         pending;
    int         stall_cycles;
    bit         quiet;
    bit         hold_req;
    logic [1:0] pin_state [NCH];
    bit         dir_up [NCH];

    quad_encoder_counter_speed_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    qecs_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offers one input transaction, after an optional gap, and waits for it
    // to be taken.
    task automatic send_event(input logic op, input logic [1:0] ch,
                              input logic a_lvl, input logic b_lvl);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0000, b_lvl, a_lvl, ch};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [1:0] ch, input logic a_lvl, input logic b_lvl);
        pin_state[ch] = {a_lvl, b_lvl};
        send_event(OP_SAMPLE, ch, a_lvl, b_lvl);
    endtask

    // The channel and level fields of a tick carry noise.
    task automatic send_tick();
        send_event(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
    endtask

    // Mostly clean quadrature steps in runs of one direction, with some
    // double steps, arbitrary levels and ticks mixed in.
    task automatic random_event();
        logic [1:0] ch;
        logic [1:0] nxt;
        int         pick;
        pick = $urandom_range(0, 99);
        ch   = 2'($urandom_range(0, NCH - 1));
        if (pick < 10) begin
            send_tick();
        end else begin
            if (pick < 80) begin
                if ($urandom_range(0, 6) == 0)
                    dir_up[ch] = !dir_up[ch];
                nxt = dir_up[ch] ? {pin_state[ch][0], ~pin_state[ch][1]}
                                 : {~pin_state[ch][0], pin_state[ch][1]};
            end else if (pick < 90) begin
                nxt = ~pin_state[ch];
            end else begin
                nxt = 2'($urandom_range(0, 3));
            end
            send_sample(ch, nxt[1], nxt[0]);
        end
    endtask

    // Drops the input, waits for every result and lets the block go idle.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * NCH + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_scaling(input logic [MULT_W-1:0] mult, input logic [SHIFT_W-1:0] shift);
        write_reg(REG_SPEED_MULT, 32'(mult));
        write_reg(REG_SPEED_SHIFT, 32'(shift));
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_SAMPLE;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            pin_state[i] = 2'b00;
            dir_up[i]    = 1'b1;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One full forward cycle on channel 0
        send_sample(2'd0, 1'b0, 1'b1);
        send_sample(2'd0, 1'b1, 1'b1);
        send_sample(2'd0, 1'b1, 1'b0);
        send_sample(2'd0, 1'b0, 1'b0);
        // Backward steps and an unchanged phase on channel 3
        send_sample(2'd3, 1'b1, 1'b0);
        send_sample(2'd3, 1'b1, 1'b1);
        send_sample(2'd3, 1'b1, 1'b1);
        // Both bits changing at once on channel 1
        send_sample(2'd1, 1'b1, 1'b1);
        send_sample(2'd1, 1'b0, 1'b0);
        // Tick with all other fields set, then one step on channel 2 and a second tick
        send_event(OP_TICK, 2'd3, 1'b1, 1'b1);
        send_sample(2'd2, 1'b0, 1'b1);
        send_event(OP_TICK, 2'd0, 1'b0, 1'b0);

        // Largest scaling: a single step saturates both ways
        settle();
        set_scaling(16'hFFFF, 5'd0);
        send_sample(2'd0, 1'b0, 1'b1);
        send_sample(2'd3, 1'b0, 1'b1);
        send_tick();

        // Random phases, the first one with a long receiver hold-off
        hold_req = 1'b1;
        repeat (PHASE_ITEMS) random_event();

        settle();
        set_scaling(16'd1, 5'd31);
        repeat (PHASE_ITEMS) random_event();

        settle();
        set_scaling(MULT_W'($urandom_range(1, 65535)), SHIFT_W'($urandom_range(0, 16)));
        repeat (PHASE_ITEMS) random_event();

        settle();
        set_scaling(16'd1, 5'd0);
        repeat (PHASE_ITEMS) random_event();

        // Final phase at the reset scaling, with no gaps on either side
        settle();
        quiet = 1'b1;
        set_scaling(SPEED_MULT_RST, SPEED_SHIFT_RST);
        repeat (PHASE_ITEMS) random_event();

        settle();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
